>>> design/line_ending_converter_assert.svh
// Assertion macros for the line ending converter checker.
// Clocked on i_clk, disabled while i_rst_n is low.
`ifndef LINE_ENDING_CONVERTER_ASSERT_SVH
`define LINE_ENDING_CONVERTER_ASSERT_SVH

// same-cycle implication
`define LEC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("line_ending_converter check failed");

// next-cycle implication
`define LEC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("line_ending_converter check failed");

`endif

>>> design/lec_pkg.sv
// Shared types and constants for the line ending converter.
// No dependencies.
package lec_pkg;

    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_FF  = 8'h0C;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CTRL_LIMIT  = 8'd32;

    localparam int COUNT_W = 32;

    localparam logic [2:0] MODE_ID = 3'd0;
    localparam logic [2:0] MODE_PU = 3'd1;
    localparam logic [2:0] MODE_UP = 3'd2;
    localparam logic [2:0] MODE_PM = 3'd3;
    localparam logic [2:0] MODE_MP = 3'd4;
    localparam logic [2:0] MODE_UM = 3'd5;
    localparam logic [2:0] MODE_MU = 3'd6;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_CTRL = 2'd1;
    localparam logic [1:0] ST_SEQ  = 2'd2;

    typedef enum logic [1:0] {
        KIND_BYTE,
        KIND_PAIR,
        KIND_STATUS
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [7:0]         data;
        logic [1:0]         status;
        logic [COUNT_W-1:0] count;
    } t_cmd;

endpackage

>>> design/lec_queue.sv
// Small command queue between the classifier and the output stage.
// Depends on lec_pkg for the command type.
module lec_queue import lec_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_push_cmd,
    output logic o_full,
    input  logic i_pop,
    output t_cmd o_pop_cmd,
    output logic o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_cmd          r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_cnt, n_cnt;

    assign o_full    = (r_cnt == FULL_CNT);
    assign o_empty   = (r_cnt == '0);
    assign o_pop_cmd = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_IDX) ? '0 : r_wr_ptr + AW'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_IDX) ? '0 : r_rd_ptr + AW'(1);
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + CW'(1);
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

endmodule

>>> design/lec_front.sv
// Input side: mode register, CR hold, error latch and termination count.
// Classifies each byte into a queue command. Depends on lec_pkg.
module lec_front import lec_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [2:0] i_cfg_wr_data,
    input  logic       i_valid,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    output logic       o_ready,
    input  logic       i_q_full,
    output logic       o_push,
    output t_cmd       o_cmd
);
    logic [2:0]         r_mode;
    logic               r_cr_held, n_cr_held;
    logic               r_err, n_err;
    logic [COUNT_W-1:0] r_count, n_count;

    logic               accept;
    logic               bump;
    logic               emit;
    logic               pc_src;
    logic               plain;
    logic [COUNT_W-1:0] count_inc;

    assign o_ready   = !i_q_full;
    assign accept    = i_valid && !i_q_full;
    assign pc_src    = (r_mode == MODE_PU) || (r_mode == MODE_PM);
    assign plain     = ((i_byte >= CTRL_LIMIT) && !i_byte[7])
                       || (i_byte == CH_TAB) || (i_byte == CH_FF);
    assign count_inc = (r_count == '1) ? r_count : r_count + COUNT_W'(1);

    always_comb begin
        n_cr_held    = r_cr_held;
        n_err        = r_err;
        bump         = 1'b0;
        emit         = 1'b0;
        o_cmd.kind   = KIND_BYTE;
        o_cmd.data   = i_byte;
        o_cmd.status = ST_OK;
        if (!r_err) begin
            emit = 1'b1;
            if (r_cr_held) begin
                n_cr_held = 1'b0;
                if (i_byte != CH_LF) begin
                    n_err        = 1'b1;
                    o_cmd.kind   = KIND_STATUS;
                    o_cmd.status = ST_SEQ;
                end else begin
                    bump       = 1'b1;
                    o_cmd.data = (r_mode == MODE_PM) ? CH_CR : CH_LF;
                end
            end else if ((r_mode == MODE_ID) || (r_mode > MODE_MU) || plain) begin
                o_cmd.kind = KIND_BYTE;
            end else if (pc_src && (i_byte == CH_CR)) begin
                if (i_last) begin
                    n_err        = 1'b1;
                    o_cmd.kind   = KIND_STATUS;
                    o_cmd.status = ST_SEQ;
                end else begin
                    n_cr_held = 1'b1;
                    emit      = 1'b0;
                end
            end else if ((r_mode == MODE_UM) && (i_byte == CH_LF)) begin
                bump       = 1'b1;
                o_cmd.data = CH_CR;
            end else if ((r_mode == MODE_MU) && (i_byte == CH_CR)) begin
                bump       = 1'b1;
                o_cmd.data = CH_LF;
            end else if (((r_mode == MODE_UP) && (i_byte == CH_LF))
                         || ((r_mode == MODE_MP) && (i_byte == CH_CR))) begin
                bump       = 1'b1;
                o_cmd.kind = KIND_PAIR;
            end else begin
                n_err        = 1'b1;
                o_cmd.kind   = KIND_STATUS;
                o_cmd.status = ST_CTRL;
            end
        end
        n_count     = bump ? count_inc : r_count;
        o_cmd.count = n_count;
        if (o_cmd.kind == KIND_STATUS) begin
            o_cmd.data = '0;
        end
        if (i_last) begin
            n_count   = '0;
            n_err     = 1'b0;
            n_cr_held = 1'b0;
        end
    end

    assign o_push = accept && emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_ID;
            r_cr_held <= 1'b0;
            r_err     <= 1'b0;
            r_count   <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_mode    <= i_cfg_wr_data;
                r_cr_held <= 1'b0;
            end else if (accept) begin
                r_cr_held <= n_cr_held;
            end
            if (accept) begin
                r_err   <= n_err;
                r_count <= n_count;
            end
        end
    end

endmodule

>>> design/lec_back.sv
// Output side: expands queue commands into result items, CR LF as two.
// Registered output with one-deep pending LF. Depends on lec_pkg.
module lec_back import lec_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_empty,
    input  t_cmd               i_q_cmd,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [7:0]         o_byte,
    output logic               o_byte_valid,
    output logic [1:0]         o_status,
    output logic               o_last,
    output logic [COUNT_W-1:0] o_count
);
    logic               r_valid;
    logic               r_pend_lf;
    logic [7:0]         r_byte;
    logic               r_bvalid;
    logic [1:0]         r_status;
    logic               r_last;
    logic [COUNT_W-1:0] r_count;
    logic               load;

    assign load  = !r_valid || i_ready;
    assign o_pop = load && !r_pend_lf && !i_q_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_pend_lf <= 1'b0;
        end else if (load) begin
            if (r_pend_lf) begin
                r_valid   <= 1'b1;
                r_pend_lf <= 1'b0;
            end else begin
                r_valid   <= !i_q_empty;
                r_pend_lf <= !i_q_empty && (i_q_cmd.kind == KIND_PAIR);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            if (r_pend_lf) begin
                r_byte <= CH_LF;
                r_last <= 1'b1;
            end else begin
                r_count  <= i_q_cmd.count;
                r_status <= i_q_cmd.status;
                case (i_q_cmd.kind)
                    KIND_PAIR: begin
                        r_byte   <= CH_CR;
                        r_bvalid <= 1'b1;
                        r_last   <= 1'b0;
                    end
                    KIND_STATUS: begin
                        r_byte   <= '0;
                        r_bvalid <= 1'b0;
                        r_last   <= 1'b1;
                    end
                    default: begin
                        r_byte   <= i_q_cmd.data;
                        r_bvalid <= 1'b1;
                        r_last   <= 1'b1;
                    end
                endcase
            end
        end
    end

    assign o_valid      = r_valid;
    assign o_byte       = r_byte;
    assign o_byte_valid = r_bvalid;
    assign o_status     = r_status;
    assign o_last       = r_last;
    assign o_count      = r_count;

endmodule

>>> design/line_ending_converter.sv
// Line ending converter: one item in per cycle unless the queue is full. Results pass
// through the command queue and the output register, which paces them: one per cycle
// while m_axis_tready holds, CR LF as two items. QUEUE_DEPTH commands between sides.
// Synchronous active-low reset clears mode, CR hold, error, count and the queue.
// Depends on lec_pkg, lec_front, lec_queue, lec_back.
module line_ending_converter import lec_pkg::*; #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_wr_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [7:0] out_byte, [39:8] terminations_changed
    output logic [2:0]  m_axis_tuser,   // [0] byte_valid, [2:1] status
    output logic        m_axis_tlast
);
    logic               q_full, q_empty, q_push, q_pop;
    t_cmd               push_cmd, pop_cmd;
    logic [7:0]         out_byte;
    logic               out_bvalid;
    logic [1:0]         out_status;
    logic [COUNT_W-1:0] out_count;

    lec_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (s_axis_tvalid),
        .i_byte        (s_axis_tdata),
        .i_last        (s_axis_tlast),
        .o_ready       (s_axis_tready),
        .i_q_full      (q_full),
        .o_push        (q_push),
        .o_cmd         (push_cmd)
    );

    lec_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (q_push),
        .i_push_cmd (push_cmd),
        .o_full     (q_full),
        .i_pop      (q_pop),
        .o_pop_cmd  (pop_cmd),
        .o_empty    (q_empty)
    );

    lec_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_empty    (q_empty),
        .i_q_cmd      (pop_cmd),
        .o_pop        (q_pop),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_byte       (out_byte),
        .o_byte_valid (out_bvalid),
        .o_status     (out_status),
        .o_last       (m_axis_tlast),
        .o_count      (out_count)
    );

    assign m_axis_tdata = {out_count, out_byte};
    assign m_axis_tuser = {out_status, out_bvalid};

endmodule

>>> design/lec_checker.sv
// Port-level checks for line_ending_converter, bound to the top level.
// Depends on lec_pkg and line_ending_converter_assert.svh.
`include "line_ending_converter_assert.svh"

module lec_checker import lec_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser,
    input logic        m_axis_tlast
);
    `LEC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    `LEC_ASSERT_NOW(a_status_alone, m_axis_tvalid && (m_axis_tuser[2:1] != ST_OK), !m_axis_tuser[0] && m_axis_tlast && (m_axis_tdata[7:0] == 8'h00))
    `LEC_ASSERT_NOW(a_first_is_cr, m_axis_tvalid && !m_axis_tlast, m_axis_tuser[0] && (m_axis_tdata[7:0] == CH_CR))
    `LEC_ASSERT_NEXT(a_cr_then_lf, m_axis_tvalid && m_axis_tready && !m_axis_tlast, m_axis_tvalid && m_axis_tlast && (m_axis_tdata[7:0] == CH_LF) && $stable(m_axis_tdata[39:8]))

endmodule

bind line_ending_converter lec_checker u_lec_checker (.*);

>>> bench/tb_line_ending_converter.sv
// Testbench for line_ending_converter: random and directed byte streams in all modes,
// checked item by item against a built-in behavioral predictor.
// Depends on lec_pkg and line_ending_converter.
module tb_line_ending_converter;
    import lec_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] MODE_UNDEF = 3'd7;
    localparam int QUIET_CYCLES = 16;
    localparam int CYCLE_LIMIT = 200000;
    localparam int ITEM_TARGET = 1050;
    localparam int PHASE_ITEMS = 105;
    localparam int HOLD_CYCLES = 400;

    typedef struct {
        logic [7:0] data;
        logic       eof;
    } t_text_byte;

    typedef struct {
        logic [7:0]         data;
        logic               valid;
        logic [1:0]         status;
        logic               last;
        logic [COUNT_W-1:0] count;
    } t_conv_out;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic [2:0]  i_cfg_wr_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tlast;

    t_text_byte  pending_bytes[$];
    t_text_byte  next_byte;
    t_conv_out   expected_out[$];

    // predictor state
    logic [2:0]         cur_mode;
    logic               cr_pend;
    logic               err_latched;
    logic [COUNT_W-1:0] term_count;

    int send_idle_pct;
    int recv_stall_pct;
    int hold_left;
    logic hold_arm;
    int err_count;
    int cycle_count;
    int items_queued;

    line_ending_converter uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (err_count < 100) begin
            $display("[%0t] %s: got %0h, expected %0h", $realtime, what, got, want);
        end
        err_count++;
    endtask

    function automatic t_conv_out byte_out(input logic [7:0] b);
        t_conv_out r;
        r.data = b;
        r.valid = 1'b1;
        r.status = ST_OK;
        r.last = 1'b0;
        r.count = '0;
        return r;
    endfunction

    function automatic t_conv_out status_out(input logic [1:0] st);
        t_conv_out r;
        r.data = 8'h00;
        r.valid = 1'b0;
        r.status = st;
        r.last = 1'b0;
        r.count = '0;
        return r;
    endfunction

    task automatic bump_terms();
        if (term_count != '1) begin
            term_count++;
        end
    endtask

    task automatic convert_byte(input logic [7:0] b, input logic eof);
        t_conv_out res[2];
        int n;
        logic pc_src;
        n = 0;
        pc_src = (cur_mode == MODE_PU || cur_mode == MODE_PM);
        if (!err_latched) begin
            if (cr_pend) begin
                cr_pend = 1'b0;
                if (b != CH_LF) begin
                    err_latched = 1'b1;
                    res[0] = status_out(ST_SEQ);
                end else begin
                    bump_terms();
                    res[0] = byte_out(cur_mode == MODE_PM ? CH_CR : CH_LF);
                end
                n = 1;
            end else if (cur_mode == MODE_ID || cur_mode > MODE_MU) begin
                res[0] = byte_out(b);
                n = 1;
            end else if ((b >= CTRL_LIMIT && !b[7]) || b == CH_TAB || b == CH_FF) begin
                res[0] = byte_out(b);
                n = 1;
            end else if (pc_src && b == CH_CR) begin
                if (eof) begin
                    err_latched = 1'b1;
                    res[0] = status_out(ST_SEQ);
                    n = 1;
                end else begin
                    cr_pend = 1'b1;
                end
            end else if ((cur_mode == MODE_UM && b == CH_LF)
                      || (cur_mode == MODE_MU && b == CH_CR)) begin
                bump_terms();
                res[0] = byte_out(cur_mode == MODE_UM ? CH_CR : CH_LF);
                n = 1;
            end else if ((cur_mode == MODE_UP && b == CH_LF)
                      || (cur_mode == MODE_MP && b == CH_CR)) begin
                bump_terms();
                res[0] = byte_out(CH_CR);
                res[1] = byte_out(CH_LF);
                n = 2;
            end else begin
                err_latched = 1'b1;
                res[0] = status_out(ST_CTRL);
                n = 1;
            end
        end
        for (int k = 0; k < n; k++) begin
            res[k].last = (k == n - 1);
            res[k].count = term_count;
            expected_out.push_back(res[k]);
        end
        if (eof) begin
            term_count = '0;
            err_latched = 1'b0;
            cr_pend = 1'b0;
        end
    endtask

    // sender: predicts on accept, then offers the next pending item
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                cur_mode = i_cfg_wr_data;
                cr_pend = 1'b0;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                convert_byte(s_axis_tdata, s_axis_tlast);
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_byte = pending_bytes.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= next_byte.data;
                    s_axis_tlast <= next_byte.eof;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off
    always @(posedge i_clk) begin
        if (hold_arm) begin
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge i_clk) begin
        m_axis_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_out.size() == 0) begin
                report_mismatch("unexpected item", {24'h0, m_axis_tdata}, 64'h0);
            end else begin
                automatic t_conv_out want = expected_out.pop_front();
                if (m_axis_tdata[7:0] !== want.data)
                    report_mismatch("out_byte", 64'(m_axis_tdata[7:0]), 64'(want.data));
                if (m_axis_tuser[0] !== want.valid)
                    report_mismatch("byte_valid", 64'(m_axis_tuser[0]), 64'(want.valid));
                if (m_axis_tuser[2:1] !== want.status)
                    report_mismatch("status", 64'(m_axis_tuser[2:1]), 64'(want.status));
                if (m_axis_tlast !== want.last)
                    report_mismatch("run_last", 64'(m_axis_tlast), 64'(want.last));
                if (m_axis_tdata[8 +: COUNT_W] !== want.count)
                    report_mismatch("terminations_changed", 64'(m_axis_tdata[8 +: COUNT_W]),
                                    64'(want.count));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic queue_byte(input logic [7:0] b, input logic eof);
        t_text_byte t;
        t.data = b;
        t.eof = eof;
        pending_bytes.push_back(t);
        items_queued++;
    endtask

    task automatic wait_idle();
        while (pending_bytes.size() != 0 || s_axis_tvalid || expected_out.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (QUIET_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_mode(input logic [2:0] m);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= m;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        @(negedge i_clk);
    endtask

    // one file of mostly well-formed text for mode m, with some noise and broken pairs
    task automatic queue_file(input logic [2:0] m, input int len);
        logic [7:0] fb[$];
        int r;
        logic pc_src;
        pc_src = (m == MODE_PU || m == MODE_PM);
        for (int i = 0; i < len; i++) begin
            r = $urandom_range(99);
            if (m == MODE_ID || m == MODE_UNDEF) begin
                fb.push_back(8'($urandom_range(255)));
            end else if (r < 68) begin
                fb.push_back(8'($urandom_range(126, 32)));
            end else if (r < 82) begin
                if (pc_src) begin
                    fb.push_back(CH_CR);
                    fb.push_back(CH_LF);
                end else if (m == MODE_UP || m == MODE_UM) begin
                    fb.push_back(CH_LF);
                end else begin
                    fb.push_back(CH_CR);
                end
            end else if (r < 88) begin
                fb.push_back($urandom_range(1) ? CH_TAB : CH_FF);
            end else if (r < 91 && pc_src) begin
                fb.push_back(CH_CR);
                fb.push_back(8'($urandom_range(255)));
            end else if (r < 94) begin
                fb.push_back(8'($urandom_range(255)));
            end else begin
                fb.push_back(8'($urandom_range(127, 32)));
            end
        end
        if (pc_src && $urandom_range(9) == 0) begin
            fb.push_back(CH_CR);
        end
        foreach (fb[i]) begin
            queue_byte(fb[i], i == fb.size() - 1);
        end
    endtask

    initial begin
        logic [2:0] mode_plan[8];
        logic [2:0] m;
        int phase;
        int phase_start;

        mode_plan = '{MODE_ID, MODE_PU, MODE_UP, MODE_PM, MODE_MP, MODE_UM, MODE_MU,
                      MODE_UNDEF};
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_wr_data = MODE_ID;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = 8'h00;
        s_axis_tlast = 1'b0;
        m_axis_tready = 1'b0;
        hold_arm = 1'b0;
        hold_left = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        err_count = 0;
        cycle_count = 0;
        items_queued = 0;
        cur_mode = MODE_ID;
        cr_pend = 1'b0;
        err_latched = 1'b0;
        term_count = '0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: PC to Unix conversion and its error paths, then PC to Mac and an undefined mode
        write_mode(MODE_PU);
        queue_byte("A", 1'b0);
        queue_byte(CH_CR, 1'b0);
        queue_byte(CH_LF, 1'b0);
        queue_byte(CH_TAB, 1'b0);
        queue_byte(CH_FF, 1'b0);
        queue_byte(8'h7E, 1'b0);
        queue_byte(CH_CR, 1'b0);
        queue_byte("x", 1'b0);       // bad sequence, latches
        queue_byte("y", 1'b0);       // dropped
        queue_byte(CH_LF, 1'b1);     // dropped, clears at end of file
        queue_byte(CH_CR, 1'b1);     // CR at end of file
        queue_byte(8'h00, 1'b1);
        queue_byte(8'h1F, 1'b0);
        queue_byte(8'h80, 1'b1);
        queue_byte(8'hFF, 1'b1);
        queue_byte(CH_CR, 1'b0);     // held, then discarded by the mode write
        wait_idle();
        write_mode(MODE_PU);
        queue_byte("A", 1'b1);
        wait_idle();
        write_mode(MODE_PM);
        queue_byte(CH_CR, 1'b0);
        queue_byte(CH_LF, 1'b1);
        wait_idle();
        write_mode(MODE_UNDEF);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'h00, 1'b0);
        queue_byte(CH_CR, 1'b1);
        wait_idle();

        phase = 0;
        while (items_queued < ITEM_TARGET) begin
            m = (phase < 8) ? mode_plan[phase] : 3'($urandom_range(7));
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
                default: begin send_idle_pct = 7; recv_stall_pct = 7; end
            endcase
            write_mode(m);
            if (phase == 2) begin
                hold_arm <= 1'b1;
                @(negedge i_clk);
                hold_arm <= 1'b0;
            end
            phase_start = items_queued;
            while (items_queued - phase_start < PHASE_ITEMS) begin
                queue_file(m, $urandom_range(3) == 0 ? $urandom_range(60, 20)
                                                     : $urandom_range(12, 1));
            end
            wait_idle();
            phase++;
        end

        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

>>> line_ending_converter.f
+incdir+design
design/lec_pkg.sv
design/lec_queue.sv
design/lec_front.sv
design/lec_back.sv
design/line_ending_converter.sv
design/lec_checker.sv
bench/tb_line_ending_converter.sv
